[rtl/ffcp_pkg.sv]
// ----------------------------------------------------------------------------
// ffcp_pkg
// Shared constants and types for the fixed frame command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ffcp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned POS_W       = 4;
   localparam int unsigned RUN_W       = 2;
   localparam int unsigned ODD_W       = 4;

   // Cells hold frame bytes 5..13 once byte 13 has been taken.
   localparam int unsigned CHAIN_DEPTH = 9;

   localparam logic [BYTE_W-1:0] HEADER_MARK  = 8'hFF;
   localparam logic [BYTE_W-1:0] TRAILER_MARK = 8'hF0;

   localparam logic [POS_W-1:0]  FIRST_POS    = 4'd2;
   localparam logic [POS_W-1:0]  ODD_LAST_POS = 4'd11;
   localparam logic [POS_W-1:0]  LAST_POS     = 4'd14;
   localparam logic [RUN_W-1:0]  HEADER_RUN   = 2'd2;

   // Cell taps at the final byte of a frame.
   localparam int unsigned TAP_TRAILER = 0;
   localparam int unsigned TAP_CHECK   = 1;
   localparam int unsigned TAP_PITCH_L = 2;
   localparam int unsigned TAP_PITCH_H = 3;
   localparam int unsigned TAP_SPEED_L = 4;
   localparam int unsigned TAP_SPEED_H = 5;
   localparam int unsigned TAP_YAW_L   = 6;
   localparam int unsigned TAP_YAW_H   = 7;
   localparam int unsigned TAP_MODE    = 8;

   typedef struct packed {
      logic             last_byte;
      logic [ODD_W-1:0] odd_count;
   } ffcp_status_type;

endpackage

`default_nettype wire

[rtl/ffcp_req_if.sv]
// ----------------------------------------------------------------------------
// ffcp_req_if
// Byte input channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/ffcp_rsp_if.sv]
// ----------------------------------------------------------------------------
// ffcp_rsp_if
// Command output channel: valid/ready handshake with decoded frame fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffcp_rsp_if;
   logic               valid;
   logic               ready;
   logic        [7:0]  mode_byte;
   logic signed [15:0] yaw_word;
   logic signed [15:0] speed_word;
   logic signed [15:0] pitch_word;

   modport source (output valid, output mode_byte, output yaw_word,
                   output speed_word, output pitch_word, input ready);
   modport sink   (input valid, input mode_byte, input yaw_word,
                   input speed_word, input pitch_word, output ready);
endinterface

`default_nettype wire

[rtl/fixed_frame_command_parser_core.sv]
// ----------------------------------------------------------------------------
// fixed_frame_command_parser_core
// 15-byte command frame parser: FF FF header, odd-byte count, F0 F0 trailer.
// ----------------------------------------------------------------------------
// Result: registered, valid in the cycle after the frame's last byte is taken.
// Throughput: one byte per cycle unless stalled; bytes shift through a row
//   of nine byte cells, so no byte waits on the previous one.
// Input stalls only while a finished result is held and not taken.
// Reset: synchronous; clears framing state and the output valid, not the cells.
`default_nettype none

module fixed_frame_command_parser_core
   import ffcp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ffcp_req_if.sink    req,
   ffcp_rsp_if.source  rsp
);

   logic              take;
   logic              frame_ok;
   ffcp_status_type   status;
   logic [BYTE_W-1:0] feed [CHAIN_DEPTH];
   logic [BYTE_W-1:0] tap  [CHAIN_DEPTH];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] mode_ff;
   logic [WORD_W-1:0] yaw_ff, speed_ff, pitch_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   ffcp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req.rx_byte),
      .status  (status)
   );

   assign feed[0] = req.rx_byte;

   for (genvar i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign feed[i] = tap[i-1];
      end
      ffcp_cell u_cell (
         .clock    (clock),
         .shift_en (take),
         .d_in     (feed[i]),
         .q_out    (tap[i])
      );
   end

   assign frame_ok = take && status.last_byte
                     && (tap[TAP_CHECK] == BYTE_W'(status.odd_count))
                     && (tap[TAP_TRAILER] == TRAILER_MARK)
                     && (req.rx_byte == TRAILER_MARK);

   assign rsp_valid_in = frame_ok || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_ok) begin
         mode_ff  <= tap[TAP_MODE];
         yaw_ff   <= {tap[TAP_YAW_H], tap[TAP_YAW_L]};
         speed_ff <= {tap[TAP_SPEED_H], tap[TAP_SPEED_L]};
         pitch_ff <= {tap[TAP_PITCH_H], tap[TAP_PITCH_L]};
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.mode_byte  = mode_ff;
   assign rsp.yaw_word   = yaw_ff;
   assign rsp.speed_word = speed_ff;
   assign rsp.pitch_word = pitch_ff;

endmodule

`default_nettype wire

[rtl/ffcp_cell.sv]
// ----------------------------------------------------------------------------
// ffcp_cell
// One byte cell of the capture chain; passes its byte on at each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ffcp_cell
   import ffcp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              shift_en,
   input  wire logic [BYTE_W-1:0] d_in,
   output logic      [BYTE_W-1:0] q_out
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   assign byte_in = shift_en ? d_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign q_out = byte_ff;

endmodule

`default_nettype wire

[rtl/ffcp_ctrl.sv]
// ----------------------------------------------------------------------------
// ffcp_ctrl
// Header hunt, frame position and running odd-byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module ffcp_ctrl
   import ffcp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output ffcp_status_type        status
);

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [ODD_W-1:0] odd_ff, odd_in;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      run_in      = run_ff;
      odd_in      = odd_ff;
      if (take) begin
         if (in_frame_ff) begin
            if (pos_ff <= ODD_LAST_POS) begin
               odd_in = odd_ff + ODD_W'(rx_byte[0]);
            end
            if (pos_ff == LAST_POS) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            run_in = (rx_byte == HEADER_MARK) ? run_ff + RUN_W'(1) : '0;
            if (run_in >= HEADER_RUN) begin
               run_in      = '0;
               in_frame_in = 1'b1;
               pos_in      = FIRST_POS;
               odd_in      = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         run_ff      <= '0;
         odd_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         run_ff      <= run_in;
         odd_ff      <= odd_in;
      end
   end

   assign status.last_byte = in_frame_ff && (pos_ff == LAST_POS);
   assign status.odd_count = odd_ff;

endmodule

`default_nettype wire

[rtl/ffcp_checker.sv]
// ----------------------------------------------------------------------------
// ffcp_checker
// Port-level checks for the command parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffcp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_mode_byte,
   input wire logic [15:0] rsp_yaw_word
);

   // A held result must not change until its transaction completes.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_byte)
                                  && $stable(rsp_yaw_word))
      else $error("rsp payload changed while stalled");

   // With no result pending the byte input is never stalled.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // Reset leaves no result pending.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   // A new result only follows a taken trailer byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_rx_byte == 8'hF0)))
      else $error("rsp without a completed frame");

endmodule

bind fixed_frame_command_parser_core ffcp_checker u_ffcp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_rx_byte   (req.rx_byte),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_mode_byte (rsp.mode_byte),
   .rsp_yaw_word  (rsp.yaw_word)
);

`default_nettype wire
